/* rtl/lruc_pkg.sv */
// Shared types and constants for the LRU key-value cache.
// Holds the item structs, the sequencer state and control types.
// No dependencies; every other file refers to it by scoped names.
package lruc_pkg;

  // Built depth default and fixed field widths
  localparam int ENTRIES_DEF = 16;
  localparam int KEY_BITS    = 16;
  localparam int VALUE_BITS  = 32;
  localparam int CAP_BITS    = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  // Command codes
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // Input item
  typedef struct packed {
    logic                          command;
    logic [KEY_BITS-1:0]           key;
    logic signed [VALUE_BITS-1:0]  value;
  } lruc_req_t;

  // Result item
  typedef struct packed {
    logic                          found;
    logic signed [VALUE_BITS-1:0]  read_value;
    logic                          evicted;
    logic [KEY_BITS-1:0]           evicted_key;
  } lruc_rsp_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE
  } lruc_state_t;

  // Control strobes from the sequencer
  typedef struct packed {
    logic idle;
    logic start;
    logic rd_en;
    logic cmp_en;
    logic apply;
  } lruc_ctrl_t;

endpackage

/* rtl/lruc_store.sv */
// Key and value memories of the LRU cache: one write port, one registered read port.
// Depends on lruc_pkg for the field widths.
module lruc_store #(
  parameter int ENTRIES = lruc_pkg::ENTRIES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rd_en,
  input  logic [$clog2(ENTRIES)-1:0]           rd_addr,
  output logic [lruc_pkg::KEY_BITS-1:0]        rd_key,
  output logic signed [lruc_pkg::VALUE_BITS-1:0] rd_value,
  input  logic [$clog2(ENTRIES)-1:0]           wr_addr,
  input  logic                                 key_we,
  input  logic                                 value_we,
  input  logic [lruc_pkg::KEY_BITS-1:0]        wr_key,
  input  logic signed [lruc_pkg::VALUE_BITS-1:0] wr_value
);

  logic [lruc_pkg::KEY_BITS-1:0]          key_mem   [ENTRIES];
  logic signed [lruc_pkg::VALUE_BITS-1:0] value_mem [ENTRIES];

  // Write ports
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (value_we) begin
      value_mem[wr_addr] <= wr_value;
    end
  end

  // Registered reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key   <= key_mem[rd_addr];
      rd_value <= value_mem[rd_addr];
    end
  end

endmodule

/* rtl/lruc_scan.sv */
// Shared compare unit of the LRU cache: checks one entry per cycle and
// tracks the first key match, the least recent entry and the first free slot.
// Depends on lruc_pkg for widths and the control struct.
module lruc_scan #(
  parameter int ENTRIES = lruc_pkg::ENTRIES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  lruc_pkg::lruc_ctrl_t                   ctrl,
  input  logic [$clog2(ENTRIES)-1:0]             cmp_idx,
  input  logic [lruc_pkg::KEY_BITS-1:0]          req_key,
  input  logic [lruc_pkg::KEY_BITS-1:0]          rd_key,
  input  logic signed [lruc_pkg::VALUE_BITS-1:0] rd_value,
  input  logic                                   slot_valid,
  input  logic [$clog2(ENTRIES)-1:0]             slot_rank,
  output logic                                   hit_found,
  output logic [$clog2(ENTRIES)-1:0]             hit_idx,
  output logic [$clog2(ENTRIES)-1:0]             hit_rank,
  output logic signed [lruc_pkg::VALUE_BITS-1:0] hit_value,
  output logic                                   vic_found,
  output logic [$clog2(ENTRIES)-1:0]             vic_idx,
  output logic [lruc_pkg::KEY_BITS-1:0]          vic_key,
  output logic                                   free_found,
  output logic [$clog2(ENTRIES)-1:0]             free_idx
);

  logic [$clog2(ENTRIES)-1:0] vic_rank;
  logic take_hit, take_vic, take_free;

  // Compare the entry that the memory just returned
  always_comb begin
    take_hit  = ctrl.cmp_en && !hit_found && slot_valid && (rd_key == req_key);
    take_vic  = ctrl.cmp_en && slot_valid && (!vic_found || slot_rank >= vic_rank);
    take_free = ctrl.cmp_en && !free_found && !slot_valid;
  end

  // Clear trackers when an item starts
  always_ff @(posedge clk) begin
    if (rst || ctrl.start) begin
      hit_found  <= 1'b0;
      vic_found  <= 1'b0;
      free_found <= 1'b0;
    end else begin
      if (take_hit)  hit_found  <= 1'b1;
      if (take_vic)  vic_found  <= 1'b1;
      if (take_free) free_found <= 1'b1;
    end
  end

  // Capture the tracked entries
  always_ff @(posedge clk) begin
    if (take_hit) begin
      hit_idx   <= cmp_idx;
      hit_rank  <= slot_rank;
      hit_value <= rd_value;
    end
    if (take_vic) begin
      vic_idx  <= cmp_idx;
      vic_rank <= slot_rank;
      vic_key  <= rd_key;
    end
    if (take_free) begin
      free_idx <= cmp_idx;
    end
  end

endmodule

/* rtl/lruc_seq.sv */
// Sequencer of the LRU cache: walks the entries through the shared compare unit
// and then, after a drain step, applies the update once the output register is free.
// Depends on lruc_pkg for the state and control types.
module lruc_seq #(
  parameter int ENTRIES = lruc_pkg::ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  input  logic                         cfg_valid,
  input  logic                         out_free,
  output lruc_pkg::lruc_ctrl_t         ctrl,
  output logic [$clog2(ENTRIES)-1:0]   rd_addr,
  output logic [$clog2(ENTRIES)-1:0]   cmp_idx
);

  localparam int IDX_W = $clog2(ENTRIES);

  lruc_pkg::lruc_state_t state, state_next;
  logic [IDX_W-1:0] count;
  logic             cmp_en;
  logic             last;

  assign last = (count == IDX_W'(ENTRIES - 1));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      lruc_pkg::ST_IDLE: begin
        if (req_valid && !cfg_valid) state_next = lruc_pkg::ST_SCAN;
      end
      lruc_pkg::ST_SCAN: begin
        if (last) state_next = lruc_pkg::ST_DRAIN;
      end
      lruc_pkg::ST_DRAIN: begin
        state_next = lruc_pkg::ST_UPDATE;
      end
      lruc_pkg::ST_UPDATE: begin
        if (out_free) state_next = lruc_pkg::ST_IDLE;
      end
      default: state_next = lruc_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    ctrl.idle   = (state == lruc_pkg::ST_IDLE);
    ctrl.start  = (state == lruc_pkg::ST_IDLE) && req_valid && !cfg_valid;
    ctrl.rd_en  = (state == lruc_pkg::ST_SCAN);
    ctrl.cmp_en = cmp_en;
    ctrl.apply  = (state == lruc_pkg::ST_UPDATE) && out_free;
    rd_addr     = count;
  end

  // Advance state and the entry counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= lruc_pkg::ST_IDLE;
      count  <= '0;
      cmp_en <= 1'b0;
    end else begin
      state  <= state_next;
      cmp_en <= ctrl.rd_en;
      if (ctrl.start) begin
        count <= '0;
      end else if (ctrl.rd_en && !last) begin
        count <= count + IDX_W'(1);
      end
    end
  end

  // Delay the read address to line up with the returned data
  always_ff @(posedge clk) begin
    cmp_idx <= count;
  end

endmodule

/* rtl/lru_key_value_cache_unit.sv */
// Top level of the LRU key-value cache: capacity register, valid bits, age ranks,
// occupancy and output register around the sequencer, compare unit and store.
// Depends on lruc_pkg, lruc_store, lruc_scan and lruc_seq.
//
//  channel | signals                      | moves
//  --------+------------------------------+-----------------------------------
//  req     | req_valid, req_stall, req    | command, key, value
//  rsp     | rsp_valid, rsp_stall, rsp    | found, read_value, evicted, evicted_key
//  cfg     | cfg_valid, cfg_ready, cfg_data | capacity
//
// An item is accepted from idle, then scanned one entry per cycle through the single
// compare unit behind the store read port; a drain step empties the read register
// and an update step applies the result. A new item is taken only back in idle,
// so the unit does not take one before it is through with the last.
// Reset (rst, synchronous) empties the store and sets capacity to 16.
// A capacity write empties the store; it is taken only while idle.
// The result register holds while rsp_stall is high; a finished item waits
// in its update step until that register is free.
module lru_key_value_cache_unit #(
  parameter int ENTRIES = lruc_pkg::ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  lruc_pkg::lruc_req_t                 req,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output lruc_pkg::lruc_rsp_t                 rsp,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lruc_pkg::CAP_BITS-1:0]       cfg_data
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int OCC_W = $clog2(ENTRIES + 1);

  lruc_pkg::lruc_ctrl_t ctrl;
  lruc_pkg::lruc_req_t  cur;
  lruc_pkg::lruc_rsp_t  rsp_next;

  logic [lruc_pkg::CAP_BITS-1:0] capacity;
  logic [ENTRIES-1:0]            valid, valid_next;
  logic [IDX_W-1:0]              rank      [ENTRIES];
  logic [IDX_W-1:0]              rank_next [ENTRIES];
  logic [OCC_W-1:0]              occupancy, occupancy_next;

  logic [IDX_W-1:0] rd_addr, cmp_idx, wr_addr, slot;
  logic [lruc_pkg::KEY_BITS-1:0]          rd_key;
  logic signed [lruc_pkg::VALUE_BITS-1:0] rd_value;

  logic                                   hit_found, vic_found, free_found;
  logic [IDX_W-1:0]                       hit_idx, hit_rank, vic_idx, free_idx;
  logic signed [lruc_pkg::VALUE_BITS-1:0] hit_value;
  logic [lruc_pkg::KEY_BITS-1:0]          vic_key;

  logic        cfg_wr, out_free, is_put, full, evict, insert, key_we, value_we;
  logic [31:0] eff_cap;

  // Handshakes
  assign cfg_ready = ctrl.idle;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign req_stall = !ctrl.idle || cfg_valid;
  assign out_free  = !rsp_valid || !rsp_stall;

  // Clamp capacity to 1..ENTRIES
  always_comb begin
    if (capacity == '0) begin
      eff_cap = 32'd1;
    end else if (32'(capacity) > 32'(ENTRIES)) begin
      eff_cap = 32'(ENTRIES);
    end else begin
      eff_cap = 32'(capacity);
    end
    full = (32'(occupancy) >= eff_cap);
  end

  lruc_seq #(.ENTRIES(ENTRIES)) u_seq (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .cfg_valid(cfg_valid),
    .out_free (out_free),
    .ctrl     (ctrl),
    .rd_addr  (rd_addr),
    .cmp_idx  (cmp_idx)
  );

  lruc_store #(.ENTRIES(ENTRIES)) u_store (
    .clk     (clk),
    .rd_en   (ctrl.rd_en),
    .rd_addr (rd_addr),
    .rd_key  (rd_key),
    .rd_value(rd_value),
    .wr_addr (wr_addr),
    .key_we  (key_we),
    .value_we(value_we),
    .wr_key  (cur.key),
    .wr_value(cur.value)
  );

  lruc_scan #(.ENTRIES(ENTRIES)) u_scan (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .cmp_idx   (cmp_idx),
    .req_key   (cur.key),
    .rd_key    (rd_key),
    .rd_value  (rd_value),
    .slot_valid(valid[cmp_idx]),
    .slot_rank (rank[cmp_idx]),
    .hit_found (hit_found),
    .hit_idx   (hit_idx),
    .hit_rank  (hit_rank),
    .hit_value (hit_value),
    .vic_found (vic_found),
    .vic_idx   (vic_idx),
    .vic_key   (vic_key),
    .free_found(free_found),
    .free_idx  (free_idx)
  );

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      cur <= req;
    end
  end

  // Decide the update from the scan results
  always_comb begin
    is_put   = (cur.command == lruc_pkg::CMD_PUT);
    evict    = !hit_found && is_put && full && vic_found;
    insert   = !hit_found && is_put && (evict || free_found);
    slot     = evict ? vic_idx : free_idx;
    wr_addr  = hit_found ? hit_idx : slot;
    key_we   = ctrl.apply && insert;
    value_we = ctrl.apply && (insert || (hit_found && is_put));
  end

  // Age ranks and valid bits after the update
  always_comb begin
    valid_next = valid;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_next[i] = rank[i];
      if (hit_found) begin
        if (IDX_W'(i) == hit_idx) begin
          rank_next[i] = '0;
        end else if (valid[i] && rank[i] < hit_rank) begin
          rank_next[i] = rank[i] + IDX_W'(1);
        end
      end else if (insert) begin
        if (IDX_W'(i) == slot) begin
          rank_next[i]  = '0;
          valid_next[i] = 1'b1;
        end else if (valid[i]) begin
          rank_next[i] = rank[i] + IDX_W'(1);
        end
      end
    end
    occupancy_next = (insert && !evict) ? occupancy + OCC_W'(1) : occupancy;
  end

  // Result of the item
  always_comb begin
    rsp_next.found       = hit_found;
    rsp_next.read_value  = (hit_found && !is_put) ? hit_value : '0;
    rsp_next.evicted     = evict;
    rsp_next.evicted_key = evict ? vic_key : '0;
  end

  // Capacity, valid bits and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= lruc_pkg::CAP_RESET;
      valid     <= '0;
      occupancy <= '0;
    end else if (cfg_wr) begin
      capacity  <= cfg_data;
      valid     <= '0;
      occupancy <= '0;
    end else if (ctrl.apply) begin
      valid     <= valid_next;
      occupancy <= occupancy_next;
    end
  end

  // Age ranks
  always_ff @(posedge clk) begin
    if (ctrl.apply) begin
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= rank_next[i];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctrl.apply) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.apply) begin
      rsp <= rsp_next;
    end
  end

  // Occupancy matches the number of valid entries
  a_occ_count: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == 32'(occupancy))
    else $error("occupancy does not match valid entries");

  // Occupancy never exceeds the clamped capacity
  a_occ_cap: assert property (@(posedge clk) disable iff (rst)
    32'(occupancy) <= eff_cap)
    else $error("occupancy above capacity");

  // A put on a new key always finds a slot
  a_put_slot: assert property (@(posedge clk) disable iff (rst)
    (ctrl.apply && is_put && !hit_found) |-> insert)
    else $error("put found no slot");

  // An eviction never reports a hit
  a_evict_miss: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.evicted) |-> !rsp.found)
    else $error("eviction on a hit");

endmodule
